@@ hw/rtl/mean_and_deviation_extremes_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for mean_and_deviation_extremes
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEAN_AND_DEVIATION_EXTREMES_ASSERT_SVH
`define MEAN_AND_DEVIATION_EXTREMES_ASSERT_SVH

// Check that a condition implies a property in the same cycle
`define MDE_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle
`define MDE_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/mde_pkg.sv @@
// ----------------------------------------------------------------------------
// mde_pkg
// Shared widths and payload types of the mean and deviation extremes block.
// ----------------------------------------------------------------------------
package mde_pkg;

    // Field widths of the input and result items, and the default store depth
    localparam int SAMPLE_BITS   = 16;
    localparam int GAP_BITS      = 16;
    localparam int COUNT_BITS    = 11;
    localparam int MAX_ITEMS_DEF = 1024;

    // One input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic        [GAP_BITS-1:0]    largest_gap;
        logic        [GAP_BITS-1:0]    smallest_gap;
        logic        [COUNT_BITS-1:0]  item_count;
        logic                          overflow;
    } t_out_item;

endpackage

@@ hw/rtl/mde_in_if.sv @@
// ----------------------------------------------------------------------------
// mde_in_if
// Valid/ready channel that carries input samples.
// ----------------------------------------------------------------------------
interface mde_in_if;
    logic              valid;
    logic              ready;
    mde_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/mde_out_if.sv @@
// ----------------------------------------------------------------------------
// mde_out_if
// Valid/ready channel that carries result items.
// ----------------------------------------------------------------------------
interface mde_out_if;
    logic               valid;
    logic               ready;
    mde_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/mean_and_deviation_extremes.sv @@
// ----------------------------------------------------------------------------
// mean_and_deviation_extremes
// Collects a set of signed samples, then reports the truncated mean and the
// largest and smallest absolute deviation of the samples from that mean.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block is loading and written
// to an internal store of MAX_ITEMS entries while a running sum and count
// are kept; samples that arrive with the store full are dropped and flag
// overflow in the result. A sample marked last closes the set: after it the
// block is busy with divider setup and a radix-2 restoring divider, then a
// scan that reads one stored sample per cycle through the single memory
// read port, and then moves the result into the output register once that
// register is free. The result register lets the next set load while a
// finished result still waits to be taken.
module mean_and_deviation_extremes #(
    parameter int MAX_ITEMS = mde_pkg::MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mde_in_if.sink    i_in,
    mde_out_if.source o_out
);

    localparam int SB        = mde_pkg::SAMPLE_BITS;
    localparam int GB        = mde_pkg::GAP_BITS;
    localparam int AW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW        = $clog2(MAX_ITEMS + 1);
    localparam int SW        = SB + CW;
    localparam int STEP_BITS = $clog2(SW + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_DIV,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state                r_state;
    logic signed [SW-1:0]  r_sum;
    logic        [CW-1:0]  r_count;
    logic                  r_drop;
    logic        [SW-1:0]  r_quo;
    logic        [CW-1:0]  r_rem;
    logic                  r_neg;
    logic [STEP_BITS-1:0]  r_step;
    logic signed [SB-1:0]  r_mean;
    logic        [CW-1:0]  r_scan_idx;
    logic                  r_rd_valid;
    logic signed [SB-1:0]  r_rd_data;
    logic        [GB-1:0]  r_largest;
    logic        [GB-1:0]  r_smallest;
    logic                  r_out_valid;
    mde_pkg::t_out_item    r_out;
    logic signed [SB-1:0]  r_mem [MAX_ITEMS];

    logic                  in_fire;
    logic                  store_ok;
    logic signed [SW-1:0]  n_sum;
    logic        [SW-1:0]  sum_mag;
    logic        [CW:0]    rem_shift;
    logic                  rem_ge;
    logic        [SW-1:0]  quo_final;
    logic signed [SB:0]    gap_diff;
    logic        [SB:0]    gap_abs;
    logic        [GB-1:0]  gap;
    logic                  out_free;

    // Handshake and load path
    assign i_in.ready  = (r_state == S_LOAD);
    assign in_fire     = i_in.valid && i_in.ready;
    assign store_ok    = (r_count < CW'(MAX_ITEMS));
    assign n_sum       = r_sum + SW'(i_in.data.sample);
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Divider step: shift one dividend bit into the partial remainder
    assign sum_mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;
    assign rem_shift = {r_rem, r_quo[SW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_count});
    assign quo_final = r_neg ? (~r_quo + SW'(1)) : r_quo;

    // Absolute deviation of the sample read back from the store
    assign gap_diff = {r_rd_data[SB-1], r_rd_data} - {r_mean[SB-1], r_mean};
    assign gap_abs  = gap_diff[SB] ? (~gap_diff + (SB+1)'(1)) : gap_diff;
    assign gap      = GB'(gap_abs);

    // Sample store: write on load, read one entry a cycle during the scan
    always_ff @(posedge i_clk) begin
        if (in_fire && store_ok) begin
            r_mem[r_count[AW-1:0]] <= i_in.data.sample;
        end
        r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
    end

    // Sequencer, divider and scan, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_sum       <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once the sink takes it, unless a new one loads
            if (r_out_valid && o_out.ready && (r_state != S_WAIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (store_ok) begin
                            r_sum   <= n_sum;
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_in.data.last) begin
                            r_state <= S_PREP;
                        end
                    end
                end

                S_PREP: begin
                    // Load the divider with the magnitude of the sum
                    r_quo   <= sum_mag;
                    r_rem   <= '0;
                    r_neg   <= r_sum[SW-1];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    // Advance one quotient bit a cycle
                    if (r_step == STEP_BITS'(SW)) begin
                        r_mean     <= SB'(quo_final);
                        r_scan_idx <= '0;
                        r_largest  <= '0;
                        r_smallest <= '1;
                        r_state    <= S_SCAN;
                    end else begin
                        r_quo  <= {r_quo[SW-2:0], rem_ge};
                        r_rem  <= rem_ge ? CW'(rem_shift - {1'b0, r_count})
                                         : rem_shift[CW-1:0];
                        r_step <= r_step + STEP_BITS'(1);
                    end
                end

                S_SCAN: begin
                    // Issue one read a cycle, fold returned gaps into max and min
                    r_rd_valid <= (r_scan_idx < r_count);
                    if (r_scan_idx < r_count) begin
                        r_scan_idx <= r_scan_idx + CW'(1);
                    end
                    if (r_rd_valid) begin
                        if (gap > r_largest) begin
                            r_largest <= gap;
                        end
                        if (gap < r_smallest) begin
                            r_smallest <= gap;
                        end
                    end
                    if ((r_scan_idx == r_count) && !r_rd_valid) begin
                        r_state <= S_WAIT;
                    end
                end

                S_WAIT: begin
                    // Hold until the output register is free, then clear the set
                    if (out_free) begin
                        r_out.mean         <= r_mean;
                        r_out.largest_gap  <= r_largest;
                        r_out.smallest_gap <= r_smallest;
                        r_out.item_count   <= mde_pkg::COUNT_BITS'(r_count);
                        r_out.overflow     <= r_drop;
                        r_out_valid        <= 1'b1;
                        r_sum              <= '0;
                        r_count            <= '0;
                        r_drop             <= 1'b0;
                        r_state            <= S_LOAD;
                    end
                end

                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Assertions
`include "mean_and_deviation_extremes_assert.svh"

    `MDE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_ITEMS), "count beyond capacity")
    `MDE_ASSERT_IMP(a_drop_full, r_drop, r_count == CW'(MAX_ITEMS), "drop without full store")
    `MDE_ASSERT_IMP(a_gap_order, r_state == S_WAIT, r_largest >= r_smallest, "gap order broken")
    `MDE_ASSERT_NXT(a_result_load, (r_state == S_WAIT) && out_free, r_out_valid && (r_count == '0), "result not loaded")

endmodule
